// ----- hdl/fast_pwm_timer_16bit_assert.svh -----
// assertion macros shared by the timer rtl
`ifndef FAST_PWM_TIMER_16BIT_ASSERT_SVH
`define FAST_PWM_TIMER_16BIT_ASSERT_SVH

// same-cycle implication on the rising clock edge, off during reset
`define FPWM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpwm check failed");

// next-cycle implication on the rising clock edge, off during reset
`define FPWM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpwm check failed");

`endif

// ----- hdl/fpwm_pkg.sv -----
package fpwm_pkg;

	// input word kinds
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_WR_A = 2'd1;
	localparam logic [1:0] MODE_WR_B = 2'd2;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_TOP      = 3'd0;
	localparam logic [2:0] REG_CLK_SEL  = 3'd1;
	localparam logic [2:0] REG_OUT_A    = 3'd2;
	localparam logic [2:0] REG_OUT_B    = 3'd3;
	localparam logic [2:0] REG_IRQ_EN   = 3'd4;

	// clock select codes
	localparam logic [2:0] CLK_SEL_MASK = 3'h7;
	localparam logic [2:0] CS_DIV1      = 3'd1;
	localparam logic [2:0] CS_DIV8      = 3'd2;
	localparam logic [2:0] CS_DIV64     = 3'd3;
	localparam logic [2:0] CS_DIV256    = 3'd4;
	localparam logic [2:0] CS_DIV1024   = 3'd5;

	// output mode codes
	localparam logic [1:0] OUT_NONINV   = 2'd2;
	localparam logic [1:0] OUT_INV      = 2'd3;

	// irq enable bits
	localparam int IRQ_OVF_BIT = 0;
	localparam int IRQ_CMPA_BIT = 1;
	localparam int IRQ_CMPB_BIT = 2;

	localparam int PRESC_W = 10;

	// per-step control shared with the channel logic
	typedef struct packed {
		logic fire;
		logic wrap;
	} step_t;

	// terminal prescaler count for a clock select
	function automatic logic [PRESC_W-1:0] fpwm_div_m1(logic [2:0] sel);
		logic [PRESC_W-1:0] r;
		case (sel & CLK_SEL_MASK)
			CS_DIV1:    r = 10'd0;
			CS_DIV8:    r = 10'd7;
			CS_DIV64:   r = 10'd63;
			CS_DIV256:  r = 10'd255;
			CS_DIV1024: r = 10'd1023;
			default:    r = 10'd0;
		endcase
		return r;
	endfunction

	// clock select actually runs the counter
	function automatic logic fpwm_running(logic [2:0] sel);
		logic r;
		case (sel & CLK_SEL_MASK)
			CS_DIV1, CS_DIV8, CS_DIV64, CS_DIV256, CS_DIV1024: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/fpwm_chan.sv -----
module fpwm_chan #(
	parameter int CounterWidth = 16
) (
	input  fpwm_pkg::step_t          step,
	input  logic [1:0]               out_mode,
	input  logic                     level,
	input  logic [CounterWidth-1:0]  cnt_next,
	input  logic [CounterWidth-1:0]  active_next,
	output logic                     match,
	output logic                     level_next
);
	import fpwm_pkg::*;

	logic inv;

	// compare only checked when the counter steps
	assign match = step.fire && (cnt_next == active_next);
	assign inv = (out_mode == OUT_INV);

	// waveform level, match beats wrap, disconnected holds
	always_comb begin
		level_next = level;
		if (out_mode == OUT_NONINV || out_mode == OUT_INV) begin
			if (match) begin
				level_next = inv;
			end else if (step.wrap) begin
				level_next = !inv;
			end
		end
	end

endmodule

// ----- hdl/fast_pwm_timer_16bit.sv -----
// fast pwm timer, two compare channels, settable top
// path: a word accepted into the input stage loads the result register once
// the result register is free, and its result word is taken from there
// throughput: one word per cycle; the result register frees the input stage
// each cycle the downstream side does not stall
// reset: arst_n clears the config registers, valid flags, prescaler, counter, compare buffers and levels
module fast_pwm_timer_16bit #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [15:0] value,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] count,
	output logic        pin_a,
	output logic        pin_a_driven,
	output logic        pin_b,
	output logic        pin_b_driven,
	output logic        irq_overflow,
	output logic        irq_compare_a,
	output logic        irq_compare_b
);
	import fpwm_pkg::*;
	`include "fast_pwm_timer_16bit_assert.svh"

	localparam int CW = COUNTER_WIDTH;

	// config registers
	logic [15:0] top_q;
	logic [2:0]  clk_sel_q;
	logic [1:0]  out_mode_a_q;
	logic [1:0]  out_mode_b_q;
	logic [2:0]  irq_en_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [15:0] value_s1;

	// timer state
	logic [PRESC_W-1:0] presc_q;
	logic [CW-1:0] counter_q;
	logic [CW-1:0] buf_a_q;
	logic [CW-1:0] buf_b_q;
	logic [CW-1:0] active_a_q;
	logic [CW-1:0] active_b_q;
	logic          level_a_q;
	logic          level_b_q;

	// step logic
	logic               proc;
	logic               tick;
	logic               at_top;
	step_t              step;
	logic [PRESC_W-1:0] presc_next;
	logic [CW-1:0]      cnt_next;
	logic [CW-1:0]      active_a_next;
	logic [CW-1:0]      active_b_next;
	logic               match_a;
	logic               match_b;
	logic               level_a_next;
	logic               level_b_next;

	logic cfg_wr;

	// apb write and read
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q        <= '0;
			clk_sel_q    <= '0;
			out_mode_a_q <= '0;
			out_mode_b_q <= '0;
			irq_en_q     <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_TOP:     top_q        <= pwdata[15:0];
				REG_CLK_SEL: clk_sel_q    <= pwdata[2:0] & CLK_SEL_MASK;
				REG_OUT_A:   out_mode_a_q <= pwdata[1:0];
				REG_OUT_B:   out_mode_b_q <= pwdata[1:0];
				REG_IRQ_EN:  irq_en_q     <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_TOP:     prdata = {16'd0, top_q};
			REG_CLK_SEL: prdata = {29'd0, clk_sel_q};
			REG_OUT_A:   prdata = {30'd0, out_mode_a_q};
			REG_OUT_B:   prdata = {30'd0, out_mode_b_q};
			REG_IRQ_EN:  prdata = {29'd0, irq_en_q};
			default:     prdata = 32'd0;
		endcase
	end

	// handshake: stage 1 moves on when the result register is free
	assign proc     = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1  <= mode;
			value_s1 <= value;
		end
	end

	// prescaler and counter step
	always_comb begin
		tick = proc && (mode_s1 == MODE_TICK) && fpwm_running(clk_sel_q);
		step.fire = tick && (presc_q >= fpwm_div_m1(clk_sel_q));
		presc_next = presc_q;
		if (tick) begin
			presc_next = step.fire ? '0 : presc_q + 1'b1;
		end
		at_top = (counter_q == CW'(top_q));
		step.wrap = step.fire && at_top;
		cnt_next = counter_q;
		if (step.fire) begin
			cnt_next = at_top ? '0 : counter_q + 1'b1;
		end
		active_a_next = step.wrap ? buf_a_q : active_a_q;
		active_b_next = step.wrap ? buf_b_q : active_b_q;
	end

	fpwm_chan #(.CounterWidth(CW)) u_chan_a (
		.step        (step),
		.out_mode    (out_mode_a_q),
		.level       (level_a_q),
		.cnt_next    (cnt_next),
		.active_next (active_a_next),
		.match       (match_a),
		.level_next  (level_a_next)
	);

	fpwm_chan #(.CounterWidth(CW)) u_chan_b (
		.step        (step),
		.out_mode    (out_mode_b_q),
		.level       (level_b_q),
		.cnt_next    (cnt_next),
		.active_next (active_b_next),
		.match       (match_b),
		.level_next  (level_b_next)
	);

	// timer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q    <= '0;
			counter_q  <= '0;
			buf_a_q    <= '0;
			buf_b_q    <= '0;
			active_a_q <= '0;
			active_b_q <= '0;
			level_a_q  <= 1'b0;
			level_b_q  <= 1'b0;
		end else if (proc) begin
			presc_q    <= presc_next;
			counter_q  <= cnt_next;
			active_a_q <= active_a_next;
			active_b_q <= active_b_next;
			level_a_q  <= level_a_next;
			level_b_q  <= level_b_next;
			if (mode_s1 == MODE_WR_A) begin
				buf_a_q <= CW'(value_s1);
			end
			if (mode_s1 == MODE_WR_B) begin
				buf_b_q <= CW'(value_s1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (proc) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			count         <= 16'(cnt_next);
			pin_a         <= level_a_next;
			pin_a_driven  <= out_mode_a_q[1];
			pin_b         <= level_b_next;
			pin_b_driven  <= out_mode_b_q[1];
			irq_overflow  <= step.wrap && irq_en_q[IRQ_OVF_BIT];
			irq_compare_a <= match_a && irq_en_q[IRQ_CMPA_BIT];
			irq_compare_b <= match_b && irq_en_q[IRQ_CMPB_BIT];
		end
	end

	// checks
	`FPWM_ASSERT_NEXT(a_hold_no_tick, proc && (mode_s1 != MODE_TICK), $stable(counter_q))
	`FPWM_ASSERT_NOW(a_ovf_zero, out_valid && irq_overflow, count == 16'd0)
	`FPWM_ASSERT_NEXT(a_s1_kept, valid_s1 && out_valid && out_stall, valid_s1)
	`FPWM_ASSERT_NOW(a_wrap_fire, step.wrap, step.fire && tick)

endmodule
